>>> src/assert_macros.svh
// assertion macros shared by the rule table builder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LRTB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LRTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define LRTB_ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`define LRTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> src/lrtb_pkg.sv
// types and constants of the rule table builder
package lrtb_pkg;

   localparam int RULE_DEPTH  = 4096;
   localparam int CODE_BITS   = 20;
   localparam int IDX_BITS    = $clog2(RULE_DEPTH);
   localparam int ID_BITS     = IDX_BITS + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic                 stream_start;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]  rule_index;
      logic [CODE_BITS-1:0] prefix_code;
      logic [CODE_BITS-1:0] first_word;
      logic                 table_full;
   } rsp_type;

   // start of stream, terminal word, rule already defined, rule not yet defined
   typedef enum logic [1:0] {
      KIND_START,
      KIND_WORD,
      KIND_HIT,
      KIND_MISS
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [CODE_BITS-1:0] code;
      logic [CODE_BITS-1:0] prefix;
      logic [IDX_BITS-1:0]  idx;
      logic                 full;
   } op_type;

endpackage

>>> src/lrtb_ram.sv
// generic single-write, single-read ram with registered read data
module lrtb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lrtb_front.sv
// front end: accepts codes, tracks rule ids and classifies each item
`include "assert_macros.svh"

module lrtb_front import lrtb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    q_push,
   output op_type  q_data,
   input  logic    q_full
);

   logic [ID_BITS-1:0]   next_id_ff;
   logic [ID_BITS-1:0]   next_id_in;
   logic [CODE_BITS-1:0] prev_code_ff;
   logic [CODE_BITS-1:0] prev_code_in;
   logic                 accept;
   logic                 full;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign full      = next_id_ff >= ID_BITS'(RULE_DEPTH);

   always_comb begin
      q_data.code   = req_item.code;
      q_data.prefix = prev_code_ff;
      q_data.idx    = IDX_BITS'(next_id_ff);
      q_data.full   = full;
      if (req_item.stream_start) begin
         q_data.kind = KIND_START;
      end else if (64'(req_item.code) >= 64'(RULE_DEPTH)) begin
         q_data.kind = KIND_WORD;
      end else if (64'(req_item.code) < 64'(next_id_ff)) begin
         q_data.kind = KIND_HIT;
      end else begin
         // code not defined yet, the previous first terminal stands in
         q_data.kind = KIND_MISS;
      end
   end

   always_comb begin
      next_id_in   = next_id_ff;
      prev_code_in = prev_code_ff;
      if (accept) begin
         prev_code_in = req_item.code;
         if (req_item.stream_start) begin
            next_id_in = '0;
         end else if (!full) begin
            next_id_in = next_id_ff + ID_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff   <= '0;
         prev_code_ff <= '0;
      end else begin
         next_id_ff   <= next_id_in;
         prev_code_ff <= prev_code_in;
      end
   end

   assign q_push = accept;

   `LRTB_ASSERT_NEXT(a_start_clears_id, clock, reset, accept && req_item.stream_start, next_id_ff == '0, "rule id not cleared at stream start")
   `LRTB_ASSERT_IMPL(a_id_in_range, clock, reset, 1'b1, next_id_ff <= ID_BITS'(RULE_DEPTH), "rule id beyond table depth")

endmodule

>>> src/lrtb_queue.sv
// short queue of classified items between front and back
`include "assert_macros.svh"

module lrtb_queue import lrtb_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_data,
   output logic   full,
   input  logic   pop,
   output logic   head_valid,
   output op_type head
);

   op_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS:0]   count_ff;
   logic                 do_push;
   logic                 do_pop;

   assign full       = count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QPTR_BITS+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QPTR_BITS+1)'(1);
         end
      end
   end

   `LRTB_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH), "queue count overflow")

endmodule

>>> src/lrtb_back.sv
// back end: first terminal table lookup and update, result register
`include "assert_macros.svh"

module lrtb_back import lrtb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  op_type  q_head,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic                 s1_valid_ff;
   op_type               s1_op_ff;
   logic                 s1_adv;
   logic [CODE_BITS-1:0] prev_first_ff;
   logic                 fwd_valid_ff;
   logic [IDX_BITS-1:0]  fwd_addr_ff;
   logic [CODE_BITS-1:0] fwd_data_ff;
   logic                 out_valid_ff;
   rsp_type              out_item_ff;
   logic                 wr_en;
   logic [IDX_BITS-1:0]  rd_addr;
   logic [CODE_BITS-1:0] rd_data;
   logic [CODE_BITS-1:0] table_first;
   logic [CODE_BITS-1:0] first;
   logic                 is_start;

   assign is_start = s1_op_ff.kind == KIND_START;
   assign s1_adv   = s1_valid_ff && (is_start || !out_valid_ff || !rsp_stall);
   assign q_pop    = q_valid && (!s1_valid_ff || s1_adv);
   assign rd_addr  = IDX_BITS'(q_head.code);
   assign wr_en    = s1_adv && !is_start && !s1_op_ff.full;

   lrtb_ram #(
      .WIDTH(CODE_BITS),
      .DEPTH(RULE_DEPTH)
   ) u_first_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(s1_op_ff.idx),
      .wr_data(prev_first_ff),
      .rd_en  (q_pop),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // the read may have raced the write of the item just ahead
   assign table_first = (fwd_valid_ff && fwd_addr_ff == IDX_BITS'(s1_op_ff.code)) ?
                        fwd_data_ff : rd_data;

   always_comb begin
      case (s1_op_ff.kind)
         KIND_WORD:  first = s1_op_ff.code;
         KIND_HIT:   first = table_first;
         KIND_MISS:  first = prev_first_ff;
         default:    first = s1_op_ff.code;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_op_ff <= q_head;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_op_ff.idx;
         fwd_data_ff <= prev_first_ff;
      end
      if (s1_adv && !is_start) begin
         out_item_ff.rule_index  <= s1_op_ff.full ? '0 : s1_op_ff.idx;
         out_item_ff.prefix_code <= s1_op_ff.prefix;
         out_item_ff.first_word  <= first;
         out_item_ff.table_full  <= s1_op_ff.full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         prev_first_ff <= '0;
         fwd_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (q_pop) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            prev_first_ff <= first;
         end
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
         if (s1_adv && !is_start) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   `LRTB_ASSERT_IMPL(a_no_result_overwrite, clock, reset, s1_adv && !is_start, !(out_valid_ff && rsp_stall), "held result overwritten")
   `LRTB_ASSERT_NEXT(a_write_forwarded, clock, reset, wr_en, fwd_valid_ff && fwd_addr_ff == $past(s1_op_ff.idx), "forward entry not updated on write")

endmodule

>>> src/lrtb_top_unused_guard.sv
// rule table builder top level helper: none

>>> src/lzw_rule_table_builder.sv
// LZW rule table builder: turns a stream of LZW codes into grammar rules
//
// req channel: one LZW code per item, stream_start marks the first code of a
// stream. That item restarts rule numbering and gives no result; every
// later code gives exactly one rsp item with the new rule's index, its prefix
// code and its first terminal word. Once all rule ids are used, results still
// come with table_full set, rule_index zero, and nothing is stored.
// Both channels use valid/stall; an item moves when valid is high and stall
// low. A four-entry queue sits between the classifying front end and the
// table back end, so the input keeps flowing while a result waits.
// Items pass a queue entry, the stage register and the result register; one
// item per cycle is sustained, set by the single read and write port of the
// first terminal ram, with the entry just written forwarded to the next read.
// While rsp_stall is high the result register holds, the back end stops and
// the queue fills; req_stall rises when the queue is full.
// Synchronous reset clears the rule counter, the previous code and first
// terminal to zero and empties queue and pipeline; the table ram is not
// cleared, since no entry is used before it is written.
module lzw_rule_table_builder import lrtb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic   q_push;
   op_type q_push_data;
   logic   q_full;
   logic   q_pop;
   logic   q_valid;
   op_type q_head;

   lrtb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .q_push   (q_push),
      .q_data   (q_push_data),
      .q_full   (q_full)
   );

   lrtb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(q_valid),
      .head      (q_head)
   );

   lrtb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

endmodule

>>> verif/testbench.sv
// self-checking testbench of the lzw rule table builder
module testbench;
   import lrtb_pkg::*;

   localparam int GAP_RANDOM = 0;
   localparam int GAP_NONE   = 1;
   localparam int GAP_SPARSE = 2;

   typedef struct {
      req_type item;
      int      gap;
      bit      drain;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   pending_type pending_q[$];
   rsp_type     rules_expected_q[$];
   bit          failed = 1'b0;
   int          gap_mode = GAP_RANDOM;
   int          results_seen = 0;
   int          hold_count = 0;
   int          holds_done = 0;

   // own copy of the builder state
   logic [CODE_BITS-1:0] rule_first_word [RULE_DEPTH];
   logic [ID_BITS-1:0]   rules_made;
   logic [CODE_BITS-1:0] last_code;
   logic [CODE_BITS-1:0] last_first_word;

   lzw_rule_table_builder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // works out the rule that one accepted code creates; a stream start resets the state instead
   function automatic void build_rule(req_type it);
      rsp_type              r;
      logic [CODE_BITS-1:0] word;
      if (it.stream_start) begin
         rules_made      = '0;
         last_code       = it.code;
         last_first_word = it.code;
         return;
      end
      if (it.code >= RULE_DEPTH)
         word = it.code;
      else if (it.code < rules_made)
         word = rule_first_word[it.code[IDX_BITS-1:0]];
      else
         word = last_first_word;
      r.table_full  = rules_made >= RULE_DEPTH;
      r.rule_index  = r.table_full ? '0 : rules_made[IDX_BITS-1:0];
      r.prefix_code = last_code;
      r.first_word  = word;
      if (!r.table_full) begin
         rule_first_word[rules_made[IDX_BITS-1:0]] = last_first_word;
         rules_made = rules_made + ID_BITS'(1);
      end
      last_code       = it.code;
      last_first_word = word;
      rules_expected_q = {rules_expected_q, r};
   endfunction

   function automatic void queue_code(logic [CODE_BITS-1:0] code, logic start, bit drain = 1'b0);
      pending_type p;
      p.item.code         = code;
      p.item.stream_start = start;
      p.drain             = drain;
      case (gap_mode)
         GAP_NONE:   p.gap = 0;
         GAP_SPARSE: p.gap = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 10) : 0;
         default:    p.gap = $urandom_range(0, 10);
      endcase
      pending_q = {pending_q, p};
   endfunction

   // made is the number of rules created so far in the current stream
   function automatic logic [CODE_BITS-1:0] make_code(kind_type kind, int made);
      int top;
      top = (made < RULE_DEPTH) ? made : RULE_DEPTH;
      case (kind)
         KIND_START:
            return CODE_BITS'($urandom_range(0, (1 << CODE_BITS) - 1));
         KIND_WORD:
            return ($urandom_range(0, 9) == 0) ? '1 :
                   CODE_BITS'($urandom_range(RULE_DEPTH, (1 << CODE_BITS) - 1));
         KIND_HIT:
            if (top > 0) return CODE_BITS'($urandom_range(0, top - 1));
            else return CODE_BITS'($urandom_range(0, RULE_DEPTH - 1));
         default:
            if (made >= RULE_DEPTH) return CODE_BITS'($urandom_range(0, RULE_DEPTH - 1));
            else if ($urandom_range(0, 3) != 0) return CODE_BITS'(made);
            else return CODE_BITS'($urandom_range(made, RULE_DEPTH - 1));
      endcase
   endfunction

   function automatic kind_type draw_kind();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) return KIND_WORD;
      if (sel < 75) return KIND_HIT;
      return KIND_MISS;
   endfunction

   // driver
   always @(posedge clock) begin : drive
      int gap_left;
      bit accepted;
      if (reset) begin
         req_valid       <= 1'b0;
         req_item        <= '0;
         gap_left        = 0;
         rules_made      = '0;
         last_code       = '0;
         last_first_word = '0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) begin
            build_rule(pending_q[0].item);
            pending_q.delete(0);
            if (pending_q.size() > 0)
               gap_left = pending_q[0].gap;
         end
         if (req_valid && !accepted) begin
            // stalled item holds
         end else if (pending_q.size() > 0 && gap_left == 0 &&
                      (!pending_q[0].drain || rules_expected_q.size() == 0)) begin
            req_valid <= 1'b1;
            req_item  <= pending_q[0].item;
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0)
               gap_left--;
         end
      end
   end

   // long receiver hold-offs so the internal queue fills and the input stalls
   always @(posedge clock) begin
      if (reset) begin
         hold_count <= 0;
         holds_done <= 0;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
      end else if ((holds_done == 0 && results_seen >= 40) ||
                   (holds_done == 1 && results_seen >= 400)) begin
         hold_count <= 90;
         holds_done <= holds_done + 1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin : observe
      int      stall_left;
      bit      recv_quiet;
      rsp_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
         recv_quiet = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (results_seen % 50 == 0)
               recv_quiet = ($urandom_range(0, 3) == 0);
            stall_left = recv_quiet ? 0 : $urandom_range(0, 10);
            if (rules_expected_q.size() == 0) begin
               $error("unexpected result item %p", rsp_item);
               failed = 1'b1;
            end else begin
               want = rules_expected_q.pop_front();
               if (rsp_item.rule_index !== want.rule_index) begin
                  $error("rule_index: expected %0d, got %0d", want.rule_index,
                         rsp_item.rule_index);
                  failed = 1'b1;
               end
               if (rsp_item.prefix_code !== want.prefix_code) begin
                  $error("prefix_code: expected %h, got %h", want.prefix_code,
                         rsp_item.prefix_code);
                  failed = 1'b1;
               end
               if (rsp_item.first_word !== want.first_word) begin
                  $error("first_word: expected %h, got %h", want.first_word,
                         rsp_item.first_word);
                  failed = 1'b1;
               end
               if (rsp_item.table_full !== want.table_full) begin
                  $error("table_full: expected %0b, got %0b", want.table_full,
                         rsp_item.table_full);
                  failed = 1'b1;
               end
            end
         end
         if (hold_count != 0) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int       made;
      int       count;
      int       len;
      kind_type kind;

      // codes before any stream start run on the reset values
      queue_code(20'h00000, 1'b0);
      queue_code(20'hFFFFF, 1'b0);
      queue_code(CODE_BITS'(RULE_DEPTH), 1'b0);
      queue_code(20'h00001, 1'b0);
      queue_code(20'h00004, 1'b0);
      queue_code(CODE_BITS'(RULE_DEPTH - 1), 1'b0);
      // rule code as the first code of a stream
      queue_code(CODE_BITS'(RULE_DEPTH - 1), 1'b1);
      queue_code(20'h00000, 1'b0);
      queue_code(20'h00000, 1'b0);
      queue_code(20'h00002, 1'b0);
      queue_code(20'hFFFFF, 1'b1);
      queue_code(20'hABCDE, 1'b0);
      queue_code(20'h00001, 1'b0);
      queue_code(20'h00001, 1'b0);
      queue_code(20'h00007, 1'b0);
      queue_code(20'h12345, 1'b1);
      queue_code(20'h00000, 1'b1);
      queue_code(CODE_BITS'(RULE_DEPTH), 1'b0);
      queue_code(20'h00000, 1'b0);

      // random streams, some noise in between
      count = 0;
      while (count < 590) begin
         gap_mode = ($urandom_range(0, 3) == 0) ? GAP_NONE : GAP_RANDOM;
         queue_code(make_code(($urandom_range(0, 1) != 0) ? KIND_HIT : KIND_WORD, 0),
                    1'b1, count == 0);
         made = 0;
         count++;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 39) == 0) begin
               queue_code(make_code(KIND_START, 0), 1'b1);
               made = 0;
            end else begin
               kind = draw_kind();
               queue_code(make_code(kind, made), 1'b0);
               made++;
            end
            count++;
         end
      end

      // a last stream reuses entries written by earlier streams
      gap_mode = GAP_SPARSE;
      queue_code(make_code(KIND_HIT, 0), 1'b1, 1'b1);
      for (made = 0; made < 30; made++)
         queue_code(make_code(draw_kind(), made), 1'b0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || rules_expected_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (failed || rules_expected_q.size() != 0)
         $display("testbench: FAIL");
      else
         $display("testbench: PASS");
      $finish;
   end

   initial begin
      #2000000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule

>>> lzw_rule_table_builder.f
+incdir+src
src/lrtb_pkg.sv
src/lrtb_ram.sv
src/lrtb_front.sv
src/lrtb_queue.sv
src/lrtb_back.sv
src/lrtb_top_unused_guard.sv
src/lzw_rule_table_builder.sv
verif/testbench.sv
